// File: hw/rtl/ebcei_pkg.sv
// ----------------------------------------------------------------------------
// ebcei_pkg
// Widths, grid and coefficient tables shared by the eta-binned cubic energy
// interpolator.
// ----------------------------------------------------------------------------
package ebcei_pkg;

  localparam int DEF_ETA_BINS   = 8;
  localparam int DEF_POLY_TERMS = 4;

  localparam int MOM_W    = 16;
  localparam int ETA_IN_W = 14;
  localparam int ENERGY_W = 24;

  localparam int P_W      = 15;
  localparam int ETA_W    = 10;
  localparam int RECIP_W  = 18;
  localparam int FRAC_W   = 25;
  localparam int FULL_W   = ETA_W + RECIP_W;
  localparam int COEF_W   = 28;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = MUL_W + P_W + 1;
  localparam int HORNER_SHIFT = 8;
  localparam int ACC_W    = PROD_W - HORNER_SHIFT;
  localparam int DIFF_W   = ACC_W + 1;
  localparam int LO_W     = 20;
  localparam int HI_W     = DIFF_W - LO_W;
  localparam int SUM_W    = 66;
  localparam int FRAC_SHIFT = 24;
  localparam int OUT_SHIFT  = 44;

  localparam logic [P_W-1:0]    P_CLAMP   = P_W'(25600);
  localparam logic [FRAC_W-1:0] ONE_Q24   = FRAC_W'(1) << FRAC_SHIFT;
  localparam logic [PROD_W-1:0] HORNER_HALF = PROD_W'(1) << (HORNER_SHIFT - 1);
  localparam logic [SUM_W-1:0]  SUM_HALF  = SUM_W'(1) << (OUT_SHIFT - 1);

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  // eta grid points in units of 1/1024
  function automatic logic [ETA_W-1:0] grid_pt(input int i);
    logic [ETA_W-1:0] g;
    case (i)
      0:       g = ETA_W'(0);
      1:       g = ETA_W'(102);
      2:       g = ETA_W'(205);
      3:       g = ETA_W'(307);
      4:       g = ETA_W'(410);
      5:       g = ETA_W'(512);
      6:       g = ETA_W'(614);
      default: g = ETA_W'(686);
    endcase
    return g;
  endfunction

  // rounded 2^24 / segment width, zero for empty segments
  function automatic logic [RECIP_W-1:0] recip(input int i);
    logic [RECIP_W-1:0] r;
    case (i)
      0, 2, 4, 5: r = RECIP_W'(164483);
      1, 3:       r = RECIP_W'(162886);
      6:          r = RECIP_W'(233017);
      default:    r = '0;
    endcase
    return r;
  endfunction

  // published coefficients in units of 1e-10
  function automatic longint coef_raw(input int r, input int j);
    longint row [4];
    longint v;
    case (r)
      0: row = '{64'sd1305705000, 64'sd3725653000, -64'sd121996200, 64'sd1806235};
      1: row = '{64'sd1296153000, 64'sd3827408000, -64'sd123864000, 64'sd1822804};
      2: row = '{64'sd1337690000, 64'sd3797454000, -64'sd124522700, 64'sd1848243};
      3: row = '{64'sd1395796000, 64'sd3623994000, -64'sd91968030,  64'sd1243278};
      4: row = '{64'sd1457184000, 64'sd3753655000, -64'sd103532400, 64'sd1473447};
      5: row = '{64'sd1329164000, 64'sd4219044000, -64'sd131051500, 64'sd1948883};
      6: row = '{64'sd813658100,  64'sd4646087000, -64'sd153191700, 64'sd2274749};
      7: row = '{64'sd1119836000, 64'sd4262497000, -64'sd116012500, 64'sd1628738};
      default: row = '{64'sd0, 64'sd0, 64'sd0, 64'sd0};
    endcase
    if (j >= 0 && j < 4) begin
      v = row[j];
    end else begin
      v = 64'sd0;
    end
    return v;
  endfunction

  // Q28 coefficient, rounded half away from zero
  function automatic coef_t coef_q28(input int r, input int j);
    longint v;
    longint mag;
    longint q;
    v   = coef_raw(r, j);
    mag = (v < 0) ? -v : v;
    q   = (mag * 64'sd268435456 + 64'sd5000000000) / 64'sd10000000000;
    return coef_t'((v < 0) ? -q : q);
  endfunction

endpackage

// File: hw/rtl/ebcei_front.sv
// ----------------------------------------------------------------------------
// ebcei_front
// Input conditioning: clamp momentum and |eta|, pick the eta segment, form
// the interpolation fraction and load the leading coefficient of both rows.
// ----------------------------------------------------------------------------
module ebcei_front import ebcei_pkg::*; #(
  parameter int ETA_BINS   = DEF_ETA_BINS,
  parameter int POLY_TERMS = DEF_POLY_TERMS,
  localparam int ROW_W     = $clog2(ETA_BINS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [MOM_W-1:0]           momentum,
  input  logic signed [ETA_IN_W-1:0] pseudorapidity,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [P_W-1:0]             out_p,
  output logic [ROW_W-1:0]           out_row,
  output logic [FRAC_W-1:0]          out_frac,
  output acc_t                       out_acc0,
  output acc_t                       out_acc1
);

  localparam int ROWS = 2 ** ROW_W;
  localparam logic [ETA_W-1:0] ETA_TOP = grid_pt(ETA_BINS - 1);

  logic [ETA_W-1:0]   grid_tbl  [ROWS];
  logic [RECIP_W-1:0] recip_tbl [ROWS];
  coef_t              top_coef  [ROWS];

  for (genvar r = 0; r < ROWS; r++) begin : g_tbl
    assign grid_tbl[r]  = grid_pt(r);
    assign recip_tbl[r] = recip(r);
    assign top_coef[r]  = coef_q28(r, POLY_TERMS - 1);
  end

  logic                v1, v2, v3;
  logic                en1, en2, en3;
  logic [P_W-1:0]      p1, p2, p3;
  logic [ETA_W-1:0]    eta1, d2;
  logic [ROW_W-1:0]    row2, row3;
  logic [FRAC_W-1:0]   frac3;
  acc_t                acc0_3, acc1_3;

  logic [ETA_IN_W-1:0] mag;
  logic [ETA_W-1:0]    eta_c;
  logic [P_W-1:0]      p_c;
  logic [ROW_W-1:0]    seg;
  logic [ROW_W-1:0]    row_up;
  logic [FULL_W-1:0]   frac_full;

  always_comb begin
    mag = $unsigned(pseudorapidity);
    if (pseudorapidity[ETA_IN_W-1]) begin
      mag = ~mag + ETA_IN_W'(1);
    end
    eta_c = (mag > ETA_IN_W'(ETA_TOP)) ? ETA_TOP : mag[ETA_W-1:0];
    p_c   = (momentum > MOM_W'(P_CLAMP)) ? P_CLAMP : momentum[P_W-1:0];
  end

  // largest inner grid point strictly below |eta|
  always_comb begin
    seg = '0;
    for (int i = 1; i < ETA_BINS - 1; i++) begin
      if (eta1 > grid_pt(i)) begin
        seg = ROW_W'(i);
      end
    end
  end

  assign frac_full = FULL_W'(d2) * FULL_W'(recip_tbl[row2]);
  assign row_up    = row2 + ROW_W'(1);

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      p1   <= p_c;
      eta1 <= eta_c;
    end
    if (en2 && v1) begin
      p2   <= p1;
      row2 <= seg;
      d2   <= eta1 - grid_tbl[seg];
    end
    if (en3 && v2) begin
      p3     <= p2;
      row3   <= row2;
      frac3  <= (frac_full > FULL_W'(ONE_Q24)) ? ONE_Q24 : frac_full[FRAC_W-1:0];
      acc0_3 <= ACC_W'(top_coef[row2]);
      acc1_3 <= ACC_W'(top_coef[row_up]);
    end
  end

  assign out_valid = v3;
  assign out_p     = p3;
  assign out_row   = row3;
  assign out_frac  = frac3;
  assign out_acc0  = acc0_3;
  assign out_acc1  = acc1_3;

`ifndef SYNTHESIS
  a_row_inner: assert property (@(posedge clk) disable iff (rst)
    v2 |-> int'(row2) <= ETA_BINS - 2)
    else $error("segment index beyond last segment");
  a_frac_unit: assert property (@(posedge clk) disable iff (rst)
    v3 |-> frac3 <= ONE_Q24)
    else $error("interpolation fraction above one");
`endif

endmodule

// File: hw/rtl/ebcei_horner.sv
// ----------------------------------------------------------------------------
// ebcei_horner
// One Horner step for the lower and upper grid rows: multiply by momentum,
// round, add the coefficient of this term.
// ----------------------------------------------------------------------------
module ebcei_horner import ebcei_pkg::*; #(
  parameter int ETA_BINS = DEF_ETA_BINS,
  parameter int TERM     = 0,
  localparam int ROW_W   = $clog2(ETA_BINS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [P_W-1:0]    in_p,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [FRAC_W-1:0] in_frac,
  input  acc_t              in_acc0,
  input  acc_t              in_acc1,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [P_W-1:0]    out_p,
  output logic [ROW_W-1:0]  out_row,
  output logic [FRAC_W-1:0] out_frac,
  output acc_t              out_acc0,
  output acc_t              out_acc1
);

  localparam int ROWS = 2 ** ROW_W;

  coef_t coef_tbl [ROWS];

  for (genvar r = 0; r < ROWS; r++) begin : g_tbl
    assign coef_tbl[r] = coef_q28(r, TERM);
  end

  logic                     va, vb;
  logic                     ena, enb;
  logic [P_W-1:0]           pa, pb;
  logic [ROW_W-1:0]         rowa, rowb;
  logic [FRAC_W-1:0]        fraca, fracb;
  logic signed [PROD_W-1:0] prod0, prod1;
  acc_t                     acc0b, acc1b;

  logic signed [P_W:0]      p_s;
  logic signed [MUL_W-1:0]  m0, m1;
  logic [PROD_W-1:0]        rnd0, rnd1;
  logic [ROW_W-1:0]         row_up;

  assign p_s    = $signed({1'b0, in_p});
  assign m0     = $signed(in_acc0[MUL_W-1:0]);
  assign m1     = $signed(in_acc1[MUL_W-1:0]);
  assign rnd0   = prod0 + HORNER_HALF;
  assign rnd1   = prod1 + HORNER_HALF;
  assign row_up = rowa + ROW_W'(1);

  assign enb      = !vb || out_ready;
  assign ena      = !va || enb;
  assign in_ready = ena;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (ena) begin
        va <= in_valid;
      end
      if (enb) begin
        vb <= va;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ena && in_valid) begin
      pa    <= in_p;
      rowa  <= in_row;
      fraca <= in_frac;
      prod0 <= m0 * p_s;
      prod1 <= m1 * p_s;
    end
    if (enb && va) begin
      pb    <= pa;
      rowb  <= rowa;
      fracb <= fraca;
      acc0b <= $signed(rnd0[PROD_W-1:HORNER_SHIFT]) + ACC_W'(coef_tbl[rowa]);
      acc1b <= $signed(rnd1[PROD_W-1:HORNER_SHIFT]) + ACC_W'(coef_tbl[row_up]);
    end
  end

  assign out_valid = vb;
  assign out_p     = pb;
  assign out_row   = rowb;
  assign out_frac  = fracb;
  assign out_acc0  = acc0b;
  assign out_acc1  = acc1b;

`ifndef SYNTHESIS
  a_step_hold: assert property (@(posedge clk) disable iff (rst)
    vb && !out_ready |=> vb && $stable(acc0b) && $stable(acc1b) && $stable(fracb))
    else $error("stalled Horner result changed");
`endif

endmodule

// File: hw/rtl/ebcei_interp.sv
// ----------------------------------------------------------------------------
// ebcei_interp
// Linear interpolation between the two row energies in eta, rounding to
// 1/256 GeV; holds the output register.
// ----------------------------------------------------------------------------
module ebcei_interp import ebcei_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [FRAC_W-1:0]          in_frac,
  input  acc_t                       in_acc0,
  input  acc_t                       in_acc1,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [ENERGY_W-1:0] energy
);

  logic                           v1, v2, v3;
  logic                           en1, en2, en3;
  acc_t                           e0_1, e0_2;
  logic signed [DIFF_W-1:0]       diff1;
  logic [FRAC_W-1:0]              frac1;
  logic signed [HI_W+FRAC_W:0]    hi2;
  logic [LO_W+FRAC_W-1:0]         lo2;
  logic signed [ENERGY_W-1:0]     energy_r;

  logic signed [FRAC_W:0]         frac_s;
  logic [SUM_W-1:0]               sum;

  assign frac_s = $signed({1'b0, frac1});

  // output range follows from the operand widths; no clipping needed
  assign sum = (SUM_W'(e0_2) << FRAC_SHIFT) + (SUM_W'(hi2) << LO_W)
             + SUM_W'(lo2) + SUM_HALF;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      e0_1  <= in_acc0;
      diff1 <= DIFF_W'(in_acc1) - DIFF_W'(in_acc0);
      frac1 <= in_frac;
    end
    if (en2 && v1) begin
      e0_2 <= e0_1;
      hi2  <= $signed(diff1[DIFF_W-1:LO_W]) * frac_s;
      lo2  <= diff1[LO_W-1:0] * frac1;
    end
    if (en3 && v2) begin
      energy_r <= ENERGY_W'($signed(sum[SUM_W-1:OUT_SHIFT]));
    end
  end

  assign out_valid = v3;
  assign energy    = energy_r;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !out_ready |=> v3 && $stable(energy_r))
    else $error("stalled energy changed");
  a_zero_span: assert property (@(posedge clk) disable iff (rst)
    v1 && en2 && diff1 == '0 |=> hi2 == '0 && lo2 == '0)
    else $error("equal rows gave nonzero slope term");
`endif

endmodule

// File: hw/rtl/eta_binned_cubic_energy_interp_top.sv
// ----------------------------------------------------------------------------
// eta_binned_cubic_energy_interp_top
// Expected deposited energy from momentum and pseudorapidity.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with momentum (1/256 GeV, unsigned) and
// pseudorapidity (1/1024, signed). A transfer happens on a rising edge with
// in_valid high and in_stall low.
// Output channel: out_valid / out_stall with energy (1/256 GeV, signed).
// A transfer happens on a rising edge with out_valid high and out_stall low.
// Path: an input passes the front-end stage registers, the multiply and
// round-and-add registers of each Horner step, then the interpolator registers.
// Throughput: one item per cycle while out_stall is low; every stage register
// then moves each cycle, and each Horner step is one momentum multiply stage
// followed by one round-and-add stage.
// Stall: while out_stall holds a result, the result and energy hold; empty
// stages ahead of it keep filling, and in_stall rises only once every stage
// holds an item.
// Reset: rst is synchronous; it empties the pipeline and out_valid drops on
// the next edge. No clearing pass; all tables are constant.
// ----------------------------------------------------------------------------
module eta_binned_cubic_energy_interp_top import ebcei_pkg::*; #(
  parameter int ETA_BINS   = DEF_ETA_BINS,
  parameter int POLY_TERMS = DEF_POLY_TERMS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [MOM_W-1:0]           momentum,
  input  logic signed [ETA_IN_W-1:0] pseudorapidity,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [ENERGY_W-1:0] energy
);

  localparam int ROW_W = $clog2(ETA_BINS);
  localparam int LAST  = POLY_TERMS - 1;

  logic              front_ready;
  logic              chain_valid [POLY_TERMS];
  logic              chain_ready [POLY_TERMS];
  logic [FRAC_W-1:0] chain_frac  [POLY_TERMS];
  acc_t              chain_acc0  [POLY_TERMS];
  acc_t              chain_acc1  [POLY_TERMS];
  logic [P_W-1:0]    chain_p     [POLY_TERMS-1];
  logic [ROW_W-1:0]  chain_row   [POLY_TERMS-1];

  assign in_stall = !front_ready;

  ebcei_front #(
    .ETA_BINS   (ETA_BINS),
    .POLY_TERMS (POLY_TERMS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (front_ready),
    .momentum       (momentum),
    .pseudorapidity (pseudorapidity),
    .out_valid      (chain_valid[0]),
    .out_ready      (chain_ready[0]),
    .out_p          (chain_p[0]),
    .out_row        (chain_row[0]),
    .out_frac       (chain_frac[0]),
    .out_acc0       (chain_acc0[0]),
    .out_acc1       (chain_acc1[0])
  );

  for (genvar k = 0; k < LAST; k++) begin : g_step
    if (k < LAST - 1) begin : g_mid
      ebcei_horner #(
        .ETA_BINS (ETA_BINS),
        .TERM     (LAST - 1 - k)
      ) u_step (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (chain_valid[k]),
        .in_ready  (chain_ready[k]),
        .in_p      (chain_p[k]),
        .in_row    (chain_row[k]),
        .in_frac   (chain_frac[k]),
        .in_acc0   (chain_acc0[k]),
        .in_acc1   (chain_acc1[k]),
        .out_valid (chain_valid[k+1]),
        .out_ready (chain_ready[k+1]),
        .out_p     (chain_p[k+1]),
        .out_row   (chain_row[k+1]),
        .out_frac  (chain_frac[k+1]),
        .out_acc0  (chain_acc0[k+1]),
        .out_acc1  (chain_acc1[k+1])
      );
    end else begin : g_end
      ebcei_horner #(
        .ETA_BINS (ETA_BINS),
        .TERM     (LAST - 1 - k)
      ) u_step (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (chain_valid[k]),
        .in_ready  (chain_ready[k]),
        .in_p      (chain_p[k]),
        .in_row    (chain_row[k]),
        .in_frac   (chain_frac[k]),
        .in_acc0   (chain_acc0[k]),
        .in_acc1   (chain_acc1[k]),
        .out_valid (chain_valid[k+1]),
        .out_ready (chain_ready[k+1]),
        .out_p     (),
        .out_row   (),
        .out_frac  (chain_frac[k+1]),
        .out_acc0  (chain_acc0[k+1]),
        .out_acc1  (chain_acc1[k+1])
      );
    end
  end

  ebcei_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[LAST]),
    .in_ready  (chain_ready[LAST]),
    .in_frac   (chain_frac[LAST]),
    .in_acc0   (chain_acc0[LAST]),
    .in_acc1   (chain_acc1[LAST]),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .energy    (energy)
  );

endmodule
